// ===== hdl/cclm_pkg.sv =====
// ----------------------------------------------------------------------------
// cclm_pkg: shared types and constants for the character list matcher
// Byte codes, register indexes, the per-cell scan state and the class test.
// ----------------------------------------------------------------------------
package cclm_pkg;

    // Register indexes on the configuration port
    localparam int unsigned IDX_W = 3;
    localparam logic [IDX_W-1:0] REG_WORD0  = 3'd0;
    localparam logic [IDX_W-1:0] REG_WORD1  = 3'd1;
    localparam logic [IDX_W-1:0] REG_WORD2  = 3'd2;
    localparam logic [IDX_W-1:0] REG_WORD3  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LENGTH = 3'd4;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned WORDS    = 4;
    localparam int unsigned WORD_BYTES = WORD_W / 8;
    localparam int unsigned LEN_W    = 6;

    // Pattern byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_HIGH   = 8'h80;

    // Class selector letters
    localparam logic [7:0] SEL_SPACE = 8'h73; // s
    localparam logic [7:0] SEL_PUNCT = 8'h70; // p
    localparam logic [7:0] SEL_DIGIT = 8'h64; // d
    localparam logic [7:0] SEL_OCT   = 8'h6F; // o
    localparam logic [7:0] SEL_HEX   = 8'h78; // x
    localparam logic [7:0] SEL_UPPER = 8'h75; // u
    localparam logic [7:0] SEL_LOWER = 8'h6C; // l
    localparam logic [7:0] SEL_ALPHA = 8'h61; // a
    localparam logic [7:0] SEL_ALNUM = 8'h6E; // n

    // Scan state handed from one cell to the next
    typedef struct packed {
        logic [7:0] ch;      // byte under test
        logic       prefix;  // still inside the leading inversion bytes
        logic [1:0] skip;    // positions still owned by the previous token
        logic       flag;    // sense of the result
        logic       hit;     // some token matched
        logic       done;    // list ended or already matched
    } scan_t;

    function automatic logic in_class(input logic [7:0] sel, input logic [7:0] c);
        logic up;
        logic lo;
        logic dig;
        logic res;
        up  = (c >= 8'h41) && (c <= 8'h5A);
        lo  = (c >= 8'h61) && (c <= 8'h7A);
        dig = (c >= 8'h30) && (c <= 8'h39);
        case (sel)
            SEL_SPACE: res = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
            SEL_PUNCT: res = ((c >= 8'd33) && (c <= 8'd47)) || ((c >= 8'd58) && (c <= 8'd64))
                          || ((c >= 8'd91) && (c <= 8'd96))
                          || ((c >= 8'd123) && (c <= 8'd126));
            SEL_DIGIT: res = dig;
            SEL_OCT:   res = dig && (c != CH_EIGHT) && (c != CH_NINE);
            SEL_HEX:   res = dig || ((c >= 8'h41) && (c <= 8'h46))
                          || ((c >= 8'h61) && (c <= 8'h66));
            SEL_UPPER: res = up;
            SEL_LOWER: res = lo;
            SEL_ALPHA: res = up || lo;
            SEL_ALNUM: res = up || lo || dig;
            CH_AT:     res = (c == CH_NUL);
            CH_CARET:  res = (c <= 8'd31) || (c == 8'd127);
            CH_TILDE:  res = (c & CH_HIGH) != CH_NUL;
            default:   res = (c == sel);
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/cclm_cell.sv =====
// ----------------------------------------------------------------------------
// cclm_cell: one pattern position of the matching chain
// Decode the token at this position against the passing byte, register state.
// ----------------------------------------------------------------------------
module cclm_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            valid_in,
    input  cclm_pkg::scan_t scan_in,
    input  logic [7:0]      b_prev,
    input  logic [7:0]      b,
    input  logic [7:0]      b_next,
    input  logic [7:0]      b_next2,
    output logic            valid_out,
    output cclm_pkg::scan_t scan_out
);

    logic            valid_reg;
    cclm_pkg::scan_t scan_reg;
    cclm_pkg::scan_t scan_next;

    logic [7:0] range_end;
    logic [7:0] range_lo;
    logic [7:0] range_hi;
    logic       range_esc;
    logic       in_range;
    logic [7:0] lit;
    logic       first;
    logic       tok;

    // range end may be escaped, unless the backslash is the last byte
    assign range_esc = (b_next == cclm_pkg::CH_BSLASH) && (b_next2 != cclm_pkg::CH_NUL);
    assign range_end = range_esc ? b_next2 : b_next;
    assign range_lo  = (b_prev > range_end) ? range_end : b_prev;
    assign range_hi  = (b_prev > range_end) ? b_prev : range_end;
    assign in_range  = (scan_in.ch >= range_lo) && (scan_in.ch <= range_hi);
    assign lit       = (b == cclm_pkg::CH_BSLASH) ? b_next : b;

    always_comb begin
        scan_next = scan_in;
        first     = 1'b0;
        tok       = 1'b0;
        if (!scan_in.done) begin
            if (scan_in.skip != 2'd0) begin
                scan_next.skip = scan_in.skip - 2'd1;
            end else begin
                if (scan_in.prefix) begin
                    if ((b == cclm_pkg::CH_BANG) || (b == cclm_pkg::CH_CARET)) begin
                        scan_next.flag = ~scan_in.flag;
                    end else begin
                        scan_next.prefix = 1'b0;
                        first            = 1'b1;
                        tok              = 1'b1;
                    end
                end else begin
                    tok = 1'b1;
                end
                if (tok) begin
                    if (b == cclm_pkg::CH_NUL) begin
                        scan_next.done = 1'b1;
                    end else if (b_next == cclm_pkg::CH_NUL) begin
                        if (scan_in.ch == b) begin
                            scan_next.hit  = 1'b1;
                            scan_next.done = 1'b1;
                        end
                    end else if (b == cclm_pkg::CH_PCT) begin
                        scan_next.skip = 2'd1;
                        if (cclm_pkg::in_class(b_next, scan_in.ch)) begin
                            scan_next.hit  = 1'b1;
                            scan_next.done = 1'b1;
                        end
                    end else if ((b == cclm_pkg::CH_DASH) && !first) begin
                        scan_next.skip = range_esc ? 2'd2 : 2'd1;
                        if (in_range) begin
                            scan_next.hit  = 1'b1;
                            scan_next.done = 1'b1;
                        end
                    end else begin
                        scan_next.skip = (b == cclm_pkg::CH_BSLASH) ? 2'd1 : 2'd0;
                        if (scan_in.ch == lit) begin
                            scan_next.hit  = 1'b1;
                            scan_next.done = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            scan_reg <= scan_next;
        end
    end

    assign valid_out = valid_reg;
    assign scan_out  = scan_reg;

    a_skip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (scan_reg.skip != 2'd3))
        else $error("cell skip count out of range");

    a_hit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && scan_reg.hit |-> scan_reg.done)
        else $error("cell hit without done");

    a_prefix_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && scan_reg.prefix |-> !scan_reg.hit && (scan_reg.skip == 2'd0))
        else $error("cell token state while still in prefix");

endmodule

// ===== hdl/char_class_list_match_unit.sv =====
// ----------------------------------------------------------------------------
// char_class_list_match_unit: bracket-style character list matcher
// Test each input byte against a configured pattern of up to 32 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Load the pattern through the write port (cfg_we, cfg_index, cfg_wdata):
//   indexes 0..3 take pattern bytes 0-7, 8-15, 16-23, 24-31 (byte i at bit
//   8*i of its word), index 4 takes the length in cfg_wdata[5:0]. Write only
//   while no beat is in flight; other indexes are dropped.
//   Bytes arrive as beats on s_valid/s_ready/s_character; one m_match beat
//   leaves on m_valid/m_ready for each, in order.
//   Throughput is one beat per cycle unless the receiver stalls. Each
//   byte walks a chain of PATTERN_BYTES cells, one pattern position per cell,
//   and the last cell's register is the output register.
//   A stalled receiver freezes the whole chain, so s_ready falls in the same
//   cycle; bubbles in the chain are kept, not squeezed out.
//   Reset clears all pattern registers (empty list, every byte gives 0) and
//   empties the chain.
// ----------------------------------------------------------------------------
module char_class_list_match_unit #(
    parameter int unsigned PATTERN_BYTES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [cclm_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cclm_pkg::WORD_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_character,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_match
);

    // Pattern registers
    logic [cclm_pkg::WORD_W-1:0] pattern_word_reg [cclm_pkg::WORDS];
    logic [cclm_pkg::LEN_W-1:0]  pattern_length_reg;
    logic [cclm_pkg::LEN_W-1:0]  len_sat;

    // Masked pattern bytes; two extra zero bytes past the end feed lookahead
    logic [7:0] pat_byte [PATTERN_BYTES+2];

    // Chain taps: tap 0 is the input, tap n+1 is the output of cell n
    logic            tap_valid [PATTERN_BYTES+1];
    cclm_pkg::scan_t tap_scan  [PATTERN_BYTES+1];
    cclm_pkg::scan_t last_scan;
    logic            adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < cclm_pkg::WORDS; w++) begin
                pattern_word_reg[w] <= '0;
            end
            pattern_length_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                cclm_pkg::REG_WORD0:  pattern_word_reg[0] <= cfg_wdata;
                cclm_pkg::REG_WORD1:  pattern_word_reg[1] <= cfg_wdata;
                cclm_pkg::REG_WORD2:  pattern_word_reg[2] <= cfg_wdata;
                cclm_pkg::REG_WORD3:  pattern_word_reg[3] <= cfg_wdata;
                cclm_pkg::REG_LENGTH: pattern_length_reg <= cfg_wdata[cclm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the length to the chain size
    assign len_sat = (pattern_length_reg > cclm_pkg::LEN_W'(PATTERN_BYTES))
                   ? cclm_pkg::LEN_W'(PATTERN_BYTES) : pattern_length_reg;

    // Bytes at or beyond the length read as zero, which ends the list
    for (genvar i = 0; i < PATTERN_BYTES + 2; i++) begin : g_bytes
        if (i < PATTERN_BYTES) begin : g_live
            assign pat_byte[i] = (cclm_pkg::LEN_W'(i) < len_sat)
                ? pattern_word_reg[i / cclm_pkg::WORD_BYTES][8*(i % cclm_pkg::WORD_BYTES) +: 8]
                : cclm_pkg::CH_NUL;
        end else begin : g_pad
            assign pat_byte[i] = cclm_pkg::CH_NUL;
        end
    end

    // Advance the chain whenever the output register is free or being taken
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // A fresh beat starts in the prefix with the sense not inverted
    assign tap_valid[0]       = s_valid;
    assign tap_scan[0].ch     = s_character;
    assign tap_scan[0].prefix = 1'b1;
    assign tap_scan[0].skip   = 2'd0;
    assign tap_scan[0].flag   = 1'b1;
    assign tap_scan[0].hit    = 1'b0;
    assign tap_scan[0].done   = 1'b0;

    for (genvar n = 0; n < PATTERN_BYTES; n++) begin : g_cell
        logic [7:0] prev_byte;
        if (n == 0) begin : g_first
            assign prev_byte = cclm_pkg::CH_NUL;
        end else begin : g_rest
            assign prev_byte = pat_byte[n-1];
        end

        cclm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .valid_in  (tap_valid[n]),
            .scan_in   (tap_scan[n]),
            .b_prev    (prev_byte),
            .b         (pat_byte[n]),
            .b_next    (pat_byte[n+1]),
            .b_next2   (pat_byte[n+2]),
            .valid_out (tap_valid[n+1]),
            .scan_out  (tap_scan[n+1])
        );
    end

    // Last cell holds the result: sense flag on a hit, its complement otherwise
    assign last_scan = tap_scan[PATTERN_BYTES];
    assign m_valid   = tap_valid[PATTERN_BYTES];
    assign m_match   = last_scan.hit ? last_scan.flag : ~last_scan.flag;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output beat present right after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> tap_valid[1])
        else $error("accepted beat did not enter the first cell");

endmodule

// ===== tb/sv/list_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_match_checker: predicts and checks the match bit of every byte beat
// Shadows the pattern registers from the write port, works out the match for
// each accepted byte and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module list_match_checker
    import cclm_pkg::*;
#(
    parameter int unsigned PAT_BYTES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [WORD_W-1:0]  cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_character,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_match,
    output int unsigned        mismatches,
    output int unsigned        pending_results
);

    typedef struct packed {
        logic [7:0] probe;
        logic       match;
    } verdict_t;

    logic [WORD_W-1:0] list_words [WORDS];
    logic [LEN_W-1:0]  list_len;
    verdict_t          expected_matches [$];

    initial begin
        mismatches      = 0;
        pending_results = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] list match check: %s", $time, msg);
        mismatches++;
    endtask

    // Bytes past the length (or past the store) read as the list end.
    function automatic logic [7:0] list_byte(input int i, input int len);
        if (i >= len || i >= PAT_BYTES)
            return CH_NUL;
        return list_words[i / WORD_BYTES][8 * (i % WORD_BYTES) +: 8];
    endfunction

    function automatic logic class_hit(input logic [7:0] sel, input logic [7:0] c);
        logic upper;
        logic lower;
        logic digit;
        upper = (c >= 8'h41) && (c <= 8'h5A);
        lower = (c >= 8'h61) && (c <= 8'h7A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        case (sel)
            SEL_SPACE: return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
            // printable, not blank, not a letter or digit
            SEL_PUNCT: return c >= 8'd33 && c <= 8'd126 && !(upper || lower || digit);
            SEL_DIGIT: return digit;
            SEL_OCT:   return digit && c != CH_EIGHT && c != CH_NINE;
            SEL_HEX:   return digit || ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66);
            SEL_UPPER: return upper;
            SEL_LOWER: return lower;
            SEL_ALPHA: return upper || lower;
            SEL_ALNUM: return upper || lower || digit;
            CH_AT:     return c == CH_NUL;
            CH_CARET:  return c <= 8'd31 || c == 8'd127;
            CH_TILDE:  return c[7];
            default:   return c == sel;
        endcase
    endfunction

    function automatic logic predict_match(input logic [7:0] c);
        int         len;
        int         first;
        int         n;
        logic       sense;
        logic [7:0] b;
        logic [7:0] lo_end;
        logic [7:0] hi_end;
        logic [7:0] swap;
        len = (list_len > PAT_BYTES) ? PAT_BYTES : list_len;
        if (len == 0)
            return 1'b0;
        sense = 1'b1;
        first = 0;
        while (first < len && (list_byte(first, len) == CH_BANG ||
                               list_byte(first, len) == CH_CARET)) begin
            first++;
            sense = ~sense;
        end
        n = first;
        while (n < len && list_byte(n, len) != CH_NUL) begin
            b = list_byte(n, len);
            if (list_byte(n + 1, len) == CH_NUL) begin
                if (c == b)
                    return sense;
            end else if (b == CH_PCT) begin
                n++;
                if (class_hit(list_byte(n, len), c))
                    return sense;
            end else if (b == CH_DASH && n > first) begin
                lo_end = list_byte(n - 1, len);
                n++;
                if (list_byte(n, len) == CH_BSLASH && list_byte(n + 1, len) != CH_NUL)
                    n++;
                hi_end = list_byte(n, len);
                if (lo_end > hi_end) begin
                    swap   = lo_end;
                    lo_end = hi_end;
                    hi_end = swap;
                end
                if (c >= lo_end && c <= hi_end)
                    return sense;
            end else begin
                if (b == CH_BSLASH)
                    n++;
                if (c == list_byte(n, len))
                    return sense;
            end
            n++;
        end
        return ~sense;
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            foreach (list_words[k])
                list_words[k] = '0;
            list_len = '0;
            expected_matches.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index <= REG_WORD3)
                    list_words[cfg_index[1:0]] = cfg_wdata;
                else if (cfg_index == REG_LENGTH)
                    list_len = cfg_wdata[LEN_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch($sformatf("result beat match=%0b with none outstanding",
                                              m_match));
                end else begin
                    want = expected_matches.pop_front();
                    if (m_match !== want.match)
                        report_mismatch($sformatf("byte 0x%02h: match %0b, expected %0b",
                                                  want.probe, m_match, want.match));
                end
            end
            if (s_valid && s_ready)
                expected_matches.push_back('{probe: s_character,
                                             match: predict_match(s_character)});
        end
        pending_results = expected_matches.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the character list matcher
// Loads a sequence of character-list patterns, directed ones first and then
// random token lists, streams bytes through the matcher under several
// sender/receiver pacing mixes and lets the checker score every match bit.
// ----------------------------------------------------------------------------
module testbench;
    import cclm_pkg::*;

    localparam int unsigned PAT_BYTES      = 32;
    localparam int unsigned RANDOM_LISTS   = 32;
    localparam int unsigned ITEMS_PER_LIST = 60;
    // Cycles with no beat on either channel before the run is declared hung.
    // The chain is 32 deep, so a healthy run never goes quiet for long.
    localparam int unsigned QUIET_LIMIT    = 3000;
    localparam int unsigned SETTLE_CYCLES  = 2 * PAT_BYTES;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [IDX_W-1:0]  cfg_index   = '0;
    logic [WORD_W-1:0] cfg_wdata   = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [7:0]        s_character = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_match;

    int unsigned mismatches;
    int unsigned pending_results;

    // Pacing knobs, percent of cycles: sender holds valid low, receiver
    // holds ready low.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    // Staging buffer for the next pattern; bytes past the chosen length keep
    // whatever is there, so the block must ignore them.
    logic [7:0]  list_buf [PAT_BYTES];
    int unsigned fill;
    int unsigned quiet_cycles = 0;

    logic [7:0] selectors [12] = '{SEL_SPACE, SEL_PUNCT, SEL_DIGIT, SEL_OCT, SEL_HEX,
                                   SEL_UPPER, SEL_LOWER, SEL_ALPHA, SEL_ALNUM,
                                   CH_AT, CH_CARET, CH_TILDE};

    always #1 aclk = ~aclk;

    char_class_list_match_unit #(
        .PATTERN_BYTES (PAT_BYTES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_match     (m_match)
    );

    list_match_checker #(
        .PAT_BYTES (PAT_BYTES)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_character     (s_character),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match         (m_match),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // Receiver: drop ready at random according to the current stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("char_class_list_match_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, optionally after some idle cycles, and hold it until
    // the block takes it. Called and returning right after a rising edge.
    task automatic send_byte(input logic [7:0] value);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= value;
        do begin
            // inputs only move at rising edges, so the falling edge shows
            // what the next rising edge will sample
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    // Drop valid and wait until every outstanding match bit has come back.
    task automatic drain;
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_results != 0);
        @(posedge aclk);
    endtask

    // Pack the staging buffer into the four words and write all five
    // registers; now and then also poke an unused index, which must be dropped.
    task automatic load_list(input int unsigned length_value);
        logic [WORD_W-1:0] word;
        int unsigned       k;
        int unsigned       j;
        for (k = 0; k < WORDS; k++) begin
            for (j = 0; j < WORD_BYTES; j++)
                word[8 * j +: 8] = list_buf[k * WORD_BYTES + j];
            cfg_we    <= 1'b1;
            cfg_index <= REG_WORD0 + IDX_W'(k);
            cfg_wdata <= word;
            @(posedge aclk);
        end
        word = {$urandom, $urandom};
        word[LEN_W-1:0] = LEN_W'(length_value);
        cfg_index <= REG_LENGTH;
        cfg_wdata <= word;
        @(posedge aclk);
        if ($urandom_range(9) == 0) begin
            cfg_index <= IDX_W'($urandom_range(7, REG_LENGTH + 1));
            cfg_wdata <= {$urandom, $urandom};
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Wait for idle, then install the staged list with the given length.
    task automatic switch_list(input int unsigned length_value);
        drain();
        load_list(length_value);
    endtask

    // Stage a directed pattern from text; the rest of the buffer is cleared.
    task automatic stage_text(input string text);
        int unsigned i;
        foreach (list_buf[i])
            list_buf[i] = CH_NUL;
        for (i = 0; i < text.len(); i++)
            list_buf[i] = text[i];
    endtask

    task automatic put_byte(input logic [7:0] value);
        list_buf[fill] = value;
        fill++;
    endtask

    // Build a random pattern: mostly well-formed token lists, some raw noise.
    task automatic build_random_list(output int unsigned length_value);
        int unsigned i;
        int unsigned pick;
        logic [7:0]  lo_end;
        logic [7:0]  hi_end;
        foreach (list_buf[i])
            list_buf[i] = 8'($urandom_range(255));
        fill = 0;
        if ($urandom_range(99) < 20) begin
            length_value = $urandom_range(63);
            return;
        end
        repeat ($urandom_range(2))
            put_byte($urandom_range(1) ? CH_BANG : CH_CARET);
        while (fill < PAT_BYTES - 3 && $urandom_range(9) != 0) begin
            case ($urandom_range(4))
                0: begin
                    // class: sometimes an unlisted selector, which is literal
                    put_byte(CH_PCT);
                    pick = $urandom_range(12);
                    put_byte(pick == 12 ? 8'($urandom_range(255, 1)) : selectors[pick]);
                end
                1: begin
                    lo_end = 8'($urandom_range(255, 1));
                    put_byte(lo_end);
                    put_byte(CH_DASH);
                    if ($urandom_range(3) == 0)
                        put_byte(CH_BSLASH);
                    // keep most ranges short so both sides of them get probed
                    if ($urandom_range(1)) begin
                        hi_end = 8'(lo_end + $urandom_range(12) - 6);
                        put_byte(hi_end == CH_NUL ? 8'h01 : hi_end);
                    end else begin
                        put_byte(8'($urandom_range(255, 1)));
                    end
                end
                2: begin
                    put_byte(CH_BSLASH);
                    put_byte(8'($urandom_range(255, 1)));
                end
                default: put_byte(8'($urandom_range(255, 1)));
            endcase
        end
        case ($urandom_range(9))
            0:       length_value = PAT_BYTES;
            1:       length_value = $urandom_range(fill);
            2:       length_value = $urandom_range(63, fill);
            default: length_value = fill;
        endcase
        // an embedded list end now and then
        if (fill > 0 && $urandom_range(9) == 0)
            list_buf[$urandom_range(fill - 1)] = CH_NUL;
    endtask

    // Bias probes toward the pattern's own bytes and their neighbors.
    function automatic logic [7:0] pick_probe();
        if ($urandom_range(1))
            return 8'(list_buf[$urandom_range(PAT_BYTES - 1)] + $urandom_range(2) - 1);
        return 8'($urandom_range(255));
    endfunction

    // Four pacing mixes, visited in turn by the random lists.
    task automatic set_pace(input int unsigned mix);
        case (mix)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 9; stall_pct = 9; end
        endcase
    endtask

    initial begin
        int unsigned list_idx;
        int unsigned length_value;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, no idling ----
        set_pace(0);

        // after reset the list is empty: every byte gives 0
        send_byte(8'h00);
        send_byte(8'hFF);

        // explicit zero length over live pattern bytes
        stage_text("abc");
        switch_list(0);
        send_byte("a");

        // a lone inversion byte: nothing can match, so the answer flips to 1
        stage_text("!");
        switch_list(1);
        send_byte("A");

        // inverted class list
        stage_text("^%d%s%p");
        switch_list(7);
        send_byte("5");
        send_byte(" ");
        send_byte("!");

        // remaining class selectors, ending in an unlisted letter
        stage_text("%o%x%u%l%a%n%@%^%~%q");
        switch_list(20);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte("q");
        send_byte("8");
        send_byte("G");

        // leading dash is literal, reversed range, escaped range end,
        // trailing backslash is literal
        stage_text("-z-a0-\\9\\");
        switch_list(9);
        send_byte("-");
        send_byte("m");
        send_byte("5");
        send_byte("\\");
        send_byte("A");

        // all-ones words with an oversized length, which saturates
        foreach (list_buf[list_idx])
            list_buf[list_idx] = 8'hFF;
        switch_list(63);
        send_byte(8'hFF);
        send_byte(8'hFE);

        // a zero byte ends the list early
        stage_text("abxcd");
        list_buf[2] = CH_NUL;
        switch_list(5);
        send_byte("c");
        send_byte("b");

        // bytes past the length are ignored even if nonzero
        stage_text("abc");
        switch_list(2);
        send_byte("c");
        send_byte("b");

        // class and range introducers in last position are plain literals
        stage_text("x%");
        switch_list(2);
        send_byte("%");
        stage_text("a-");
        switch_list(2);
        send_byte("-");
        send_byte("b");

        // ---- random lists under each pacing mix ----
        for (list_idx = 0; list_idx < RANDOM_LISTS; list_idx++) begin
            build_random_list(length_value);
            switch_list(length_value);
            set_pace(list_idx % 4);
            repeat (ITEMS_PER_LIST)
                send_byte(pick_probe());
        end

        // Wait out the tail and any stray beats the chain might still emit.
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatches == 0)
            $display("char_class_list_match_unit regression: pass");
        else
            $display("char_class_list_match_unit regression: fail");
        $finish;
    end

endmodule
